[rtl/core/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// Distance constraint projection package
// Widths, the per-item payload record and the coordinate saturation function.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int CW    = 20;
  localparam int GB    = 8;
  localparam int DW    = CW + 1;
  localparam int SW    = 2 * DW;
  localparam int RADW  = SW + 2 * GB;
  localparam int RW    = RADW / 2;
  localparam int REMW  = RW + 3;
  localparam int DIFFW = RW + 1;
  localparam int DENW  = RW + 1;
  localparam int DPW   = RW + 2;
  localparam int NW    = DW + RW;
  localparam int NPW   = NW + 2;
  localparam int QW    = CW + 2;
  localparam int CMPW  = DPW + QW;
  localparam int SUMW  = QW + 2;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic                 lock1;
    logic                 lock2;
    logic [CW-2:0]        rest;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic                 negx;
    logic                 negy;
    logic                 coinc;
  } pass_t;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((2 ** (CW - 1)) - 1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/distance_constraint_projection.sv]
// ----------------------------------------------------------------------------
// Distance constraint projection
// Moves a pair of 2D points along their joining line toward a rest length.
// ----------------------------------------------------------------------------
// The block accepts one point pair per clock while the output is not stalled
// and returns one result per pair, in order. The square root and the two
// dividers resolve one result bit per pipeline stage. A stall on the output
// holds the whole pipeline; nothing is lost or repeated.
module distance_constraint_projection (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, second_x, second_y, rest_length, zero padding
  input  logic [103:0] in_tdata,
  // first_locked, second_locked
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_first_x, new_first_y, new_second_x, new_second_y
  output logic [79:0]  out_tdata,
  // coincident
  output logic         out_tuser
);

  localparam int CW   = dcp_pkg::CW;
  localparam int RW   = dcp_pkg::RW;
  localparam int QW   = dcp_pkg::QW;
  localparam int SW   = dcp_pkg::SW;
  localparam int RADW = dcp_pkg::RADW;
  localparam int REMW = dcp_pkg::REMW;
  localparam int GB   = dcp_pkg::GB;
  localparam int DIFFW = dcp_pkg::DIFFW;
  localparam int DENW = dcp_pkg::DENW;
  localparam int DPW  = dcp_pkg::DPW;
  localparam int NW   = dcp_pkg::NW;
  localparam int NPW  = dcp_pkg::NPW;
  localparam int CMPW = dcp_pkg::CMPW;
  localparam int SUMW = dcp_pkg::SUMW;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage A: differences and magnitudes.
  dcp_pkg::pass_t a_pass_r, a_pass_nxt;
  logic           a_vld_r;
  logic signed [CW:0] dxs, dys;

  always_comb begin
    a_pass_nxt.x1    = in_tdata[CW-1:0];
    a_pass_nxt.y1    = in_tdata[2*CW-1:CW];
    a_pass_nxt.x2    = in_tdata[3*CW-1:2*CW];
    a_pass_nxt.y2    = in_tdata[4*CW-1:3*CW];
    a_pass_nxt.rest  = in_tdata[5*CW-2:4*CW];
    a_pass_nxt.lock1 = in_tuser[0];
    a_pass_nxt.lock2 = in_tuser[1];
    dxs = {a_pass_nxt.x2[CW-1], a_pass_nxt.x2} - {a_pass_nxt.x1[CW-1], a_pass_nxt.x1};
    dys = {a_pass_nxt.y2[CW-1], a_pass_nxt.y2} - {a_pass_nxt.y1[CW-1], a_pass_nxt.y1};
    a_pass_nxt.negx  = dxs[CW];
    a_pass_nxt.negy  = dys[CW];
    a_pass_nxt.adx   = dxs[CW] ? -dxs : dxs;
    a_pass_nxt.ady   = dys[CW] ? -dys : dys;
    a_pass_nxt.coinc = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
    end
    if (adv) begin
      a_pass_r <= a_pass_nxt;
    end
  end

  // Stage B: squares.
  dcp_pkg::pass_t b_pass_r;
  logic           b_vld_r;
  logic [SW-1:0]  b_sqx_r, b_sqy_r, sqx_nxt, sqy_nxt;

  assign sqx_nxt = a_pass_r.adx * a_pass_r.adx;
  assign sqy_nxt = a_pass_r.ady * a_pass_r.ady;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
    if (adv) begin
      b_pass_r <= a_pass_r;
      b_sqx_r  <= sqx_nxt;
      b_sqy_r  <= sqy_nxt;
    end
  end

  // Square root, one root bit per stage.
  dcp_pkg::pass_t  sq_pass_r [0:RW];
  logic            sq_vld_r  [0:RW];
  logic [REMW-1:0] sq_rem_r  [0:RW];
  logic [RW-1:0]   sq_root_r [0:RW];
  logic [RADW-1:0] sq_rad_r  [0:RW];
  logic [SW-1:0]   s_sum;
  dcp_pkg::pass_t  sq0_pass_nxt;

  assign s_sum = b_sqx_r + b_sqy_r;

  always_comb begin
    sq0_pass_nxt       = b_pass_r;
    sq0_pass_nxt.coinc = (s_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= b_vld_r;
    end
    if (adv) begin
      sq_pass_r[0] <= sq0_pass_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= {s_sum, {(2*GB){1'b0}}};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            take;
    assign rem_sh = {sq_rem_r[k][REMW-3:0], sq_rad_r[k][RADW-1:RADW-2]};
    assign trial  = {1'b0, sq_root_r[k], 2'b01};
    assign take   = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      if (adv) begin
        sq_pass_r[k+1] <= sq_pass_r[k];
        sq_rad_r[k+1]  <= {sq_rad_r[k][RADW-3:0], 2'b00};
        sq_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][RW-2:0], take};
      end
    end
  end

  // Stage D: length error and denominator.
  dcp_pkg::pass_t   d_pass_r;
  logic             d_vld_r, d_neg_r;
  logic [RW-1:0]    d_mag_r;
  logic [DENW-1:0]  d_den_r;
  logic [DIFFW-1:0] diffv, diffn;
  logic [RW-1:0]    root;

  assign root  = sq_root_r[RW];
  assign diffv = DIFFW'({sq_pass_r[RW].rest, {GB{1'b0}}}) - DIFFW'(root);
  assign diffn = -diffv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= sq_vld_r[RW];
    end
    if (adv) begin
      d_pass_r <= sq_pass_r[RW];
      d_neg_r  <= diffv[DIFFW-1];
      d_mag_r  <= diffv[DIFFW-1] ? diffn[RW-1:0] : diffv[RW-1:0];
      d_den_r  <= (sq_pass_r[RW].lock1 || sq_pass_r[RW].lock2) ? {1'b0, root} : {root, 1'b0};
    end
  end

  // Stage E: numerators.
  dcp_pkg::pass_t  e_pass_r;
  logic            e_vld_r, e_neg_r;
  logic [DENW-1:0] e_den_r;
  logic [NW-1:0]   e_nx_r, e_ny_r, nx_nxt, ny_nxt;

  assign nx_nxt = d_pass_r.adx * d_mag_r;
  assign ny_nxt = d_pass_r.ady * d_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r;
    end
    if (adv) begin
      e_pass_r <= d_pass_r;
      e_neg_r  <= d_neg_r;
      e_den_r  <= d_den_r;
      e_nx_r   <= nx_nxt;
      e_ny_r   <= ny_nxt;
    end
  end

  // Rounded dividers, one quotient bit per stage, for both axes.
  dcp_pkg::pass_t dv_pass_r [0:QW];
  logic           dv_vld_r  [0:QW];
  logic           dv_neg_r  [0:QW];
  logic [DPW-1:0] dv_den_r  [0:QW];
  logic [NPW-1:0] dv_remx_r [0:QW];
  logic [NPW-1:0] dv_remy_r [0:QW];
  logic [QW-1:0]  dv_qx_r   [0:QW];
  logic [QW-1:0]  dv_qy_r   [0:QW];
  logic           dv_ovx_r  [0:QW];
  logic           dv_ovy_r  [0:QW];
  logic [NPW-1:0] nump_x, nump_y;
  logic [DPW-1:0] den2;
  logic [CMPW-1:0] den_top;

  assign den2    = {e_den_r, 1'b0};
  assign nump_x  = NPW'({e_nx_r, 1'b0}) + NPW'(e_den_r);
  assign nump_y  = NPW'({e_ny_r, 1'b0}) + NPW'(e_den_r);
  assign den_top = {den2, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= e_vld_r;
    end
    if (adv) begin
      dv_pass_r[0] <= e_pass_r;
      dv_neg_r[0]  <= e_neg_r;
      dv_den_r[0]  <= den2;
      dv_remx_r[0] <= nump_x;
      dv_remy_r[0] <= nump_y;
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
      dv_ovx_r[0]  <= CMPW'(nump_x) >= den_top;
      dv_ovy_r[0]  <= CMPW'(nump_y) >= den_top;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [CMPW-1:0] sh;
    logic            tx, ty;
    assign sh = CMPW'(dv_den_r[j]) << (QW - 1 - j);
    assign tx = CMPW'(dv_remx_r[j]) >= sh;
    assign ty = CMPW'(dv_remy_r[j]) >= sh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      if (adv) begin
        dv_pass_r[j+1] <= dv_pass_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_den_r[j+1]  <= dv_den_r[j];
        dv_ovx_r[j+1]  <= dv_ovx_r[j];
        dv_ovy_r[j+1]  <= dv_ovy_r[j];
        dv_remx_r[j+1] <= tx ? dv_remx_r[j] - sh[NPW-1:0] : dv_remx_r[j];
        dv_remy_r[j+1] <= ty ? dv_remy_r[j] - sh[NPW-1:0] : dv_remy_r[j];
        dv_qx_r[j+1]   <= {dv_qx_r[j][QW-2:0], tx};
        dv_qy_r[j+1]   <= {dv_qy_r[j][QW-2:0], ty};
      end
    end
  end

  // Output stage: apply offsets and saturate.
  dcp_pkg::pass_t      fp;
  logic [QW-1:0]       qmx, qmy;
  logic signed [SUMW-1:0] ox, oy;
  logic signed [CW-1:0] nx1, ny1, nx2, ny2;
  logic                out_vld_r;
  logic [79:0]         out_data_r, out_data_nxt;
  logic                out_coinc_r;

  always_comb begin
    fp  = dv_pass_r[QW];
    qmx = dv_ovx_r[QW] ? '1 : dv_qx_r[QW];
    qmy = dv_ovy_r[QW] ? '1 : dv_qy_r[QW];
    ox  = (fp.negx ^ dv_neg_r[QW]) ? -SUMW'(qmx) : SUMW'(qmx);
    oy  = (fp.negy ^ dv_neg_r[QW]) ? -SUMW'(qmy) : SUMW'(qmy);
    nx1 = fp.x1;
    ny1 = fp.y1;
    nx2 = fp.x2;
    ny2 = fp.y2;
    if (!fp.coinc && !(fp.lock1 && fp.lock2)) begin
      if (!fp.lock1) begin
        nx1 = dcp_pkg::sat_coord(SUMW'(fp.x1) - ox);
        ny1 = dcp_pkg::sat_coord(SUMW'(fp.y1) - oy);
      end
      if (!fp.lock2) begin
        nx2 = dcp_pkg::sat_coord(SUMW'(fp.x2) + ox);
        ny2 = dcp_pkg::sat_coord(SUMW'(fp.y2) + oy);
      end
    end
    out_data_nxt = {ny2, nx2, ny1, nx1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld_r[QW];
    end
    if (adv) begin
      out_data_r  <= out_data_nxt;
      out_coinc_r <= fp.coinc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_coinc_r;

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready does not follow the output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(sq_vld_r[RW]) && $stable(dv_vld_r[QW]) && $stable(out_tdata))
    else $error("pipeline moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> a_vld_r)
    else $error("accepted request did not enter the pipeline");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
